>>> hw/rtl/rlvc_pkg.sv
// ----------------------------------------------------------------------------
// rlvc_pkg
// Shared widths, register indexes, reset values and bundle types of the
// rate limited velocity command block.
// ----------------------------------------------------------------------------
package rlvc_pkg;

	localparam int CFG_W  = 15;
	localparam int ANG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int FRAC_W = 12;
	localparam int MAG_W  = 17;
	localparam int WIDE_W = 19;

	// fixed linear ramp-down step of rotate mode, 0.1 in Q3.12
	localparam logic [CFG_W-1:0] ROT_LIN_STEP = 15'd410;

	// register indexes
	localparam logic [IDX_W-1:0] REG_HEADING_BAND      = 3'd0;
	localparam logic [IDX_W-1:0] REG_ANGULAR_ACCEL     = 3'd1;
	localparam logic [IDX_W-1:0] REG_ANGULAR_STEP      = 3'd2;
	localparam logic [IDX_W-1:0] REG_LINEAR_STEP       = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_ANGULAR       = 3'd4;
	localparam logic [IDX_W-1:0] REG_MIN_ANGULAR       = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX_LINEAR        = 3'd6;
	localparam logic [IDX_W-1:0] REG_INV_HORIZON       = 3'd7;

	// register reset values
	localparam logic [CFG_W-1:0] RST_HEADING_BAND      = 15'd205;
	localparam logic [CFG_W-1:0] RST_ANGULAR_ACCEL     = 15'd4096;
	localparam logic [CFG_W-1:0] RST_ANGULAR_STEP      = 15'd410;
	localparam logic [CFG_W-1:0] RST_LINEAR_STEP       = 15'd410;
	localparam logic [CFG_W-1:0] RST_MAX_ANGULAR       = 15'd4096;
	localparam logic [CFG_W-1:0] RST_MIN_ANGULAR       = 15'd1024;
	localparam logic [CFG_W-1:0] RST_MAX_LINEAR        = 15'd2048;
	localparam logic [CFG_W-1:0] RST_INV_HORIZON       = 15'd4096;

	typedef struct packed {
		logic [CFG_W-1:0] heading_band;
		logic [CFG_W-1:0] angular_accel;
		logic [CFG_W-1:0] angular_step;
		logic [CFG_W-1:0] linear_step;
		logic [CFG_W-1:0] max_angular;
		logic [CFG_W-1:0] min_angular;
		logic [CFG_W-1:0] max_linear;
		logic [CFG_W-1:0] inv_horizon;
	} cfg_t;

	// state independent terms of one transaction, computed on accept
	typedef struct packed {
		logic             mode;
		logic             neg;
		logic             in_band;
		logic             slow;
		logic [CFG_W-1:0] lin_tgt;
		logic [ANG_W-1:0] ang_tgt;
	} prep_t;

	function automatic logic [WIDE_W-1:0] abs_wide(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] r;
		r = v[WIDE_W-1] ? $unsigned(-v) : $unsigned(v);
		return r;
	endfunction

endpackage

>>> hw/rtl/rlvc_regs.sv
// ----------------------------------------------------------------------------
// rlvc_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rlvc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rlvc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [rlvc_pkg::CFG_W-1:0]    cfg_data,
	output rlvc_pkg::cfg_t                cfg
);

	rlvc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heading_band      <= rlvc_pkg::RST_HEADING_BAND;
			cfg_q.angular_accel     <= rlvc_pkg::RST_ANGULAR_ACCEL;
			cfg_q.angular_step      <= rlvc_pkg::RST_ANGULAR_STEP;
			cfg_q.linear_step       <= rlvc_pkg::RST_LINEAR_STEP;
			cfg_q.max_angular       <= rlvc_pkg::RST_MAX_ANGULAR;
			cfg_q.min_angular       <= rlvc_pkg::RST_MIN_ANGULAR;
			cfg_q.max_linear        <= rlvc_pkg::RST_MAX_LINEAR;
			cfg_q.inv_horizon       <= rlvc_pkg::RST_INV_HORIZON;
		end else if (cfg_we) begin
			case (cfg_index)
				rlvc_pkg::REG_HEADING_BAND:      cfg_q.heading_band      <= cfg_data;
				rlvc_pkg::REG_ANGULAR_ACCEL:     cfg_q.angular_accel     <= cfg_data;
				rlvc_pkg::REG_ANGULAR_STEP:      cfg_q.angular_step      <= cfg_data;
				rlvc_pkg::REG_LINEAR_STEP:       cfg_q.linear_step       <= cfg_data;
				rlvc_pkg::REG_MAX_ANGULAR:       cfg_q.max_angular       <= cfg_data;
				rlvc_pkg::REG_MIN_ANGULAR:       cfg_q.min_angular       <= cfg_data;
				rlvc_pkg::REG_MAX_LINEAR:        cfg_q.max_linear        <= cfg_data;
				rlvc_pkg::REG_INV_HORIZON:       cfg_q.inv_horizon       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/rlvc_prep.sv
// ----------------------------------------------------------------------------
// rlvc_prep
// Input side terms: angle magnitude, accuracy band and slow-down tests, and
// the capped drive targets distance and angle times the inverse horizon.
// ----------------------------------------------------------------------------
module rlvc_prep (
	input  logic                              mode,
	input  logic signed [rlvc_pkg::ANG_W-1:0] angle,
	input  logic [rlvc_pkg::CFG_W-1:0]        distance,
	input  rlvc_pkg::cfg_t                    cfg,
	output rlvc_pkg::prep_t                   prep
);

	logic [rlvc_pkg::MAG_W-1:0]   ang_ext;
	logic [rlvc_pkg::MAG_W-1:0]   mag;
	logic [31:0]                  accel_prod;
	logic [31:0]                  ang_prod;
	logic [29:0]                  lin_prod;
	logic [19:0]                  ang_scaled;
	logic [17:0]                  lin_scaled;
	logic [rlvc_pkg::CFG_W-1:0]   ang_cap;

	assign ang_ext = {angle[rlvc_pkg::ANG_W-1], angle};
	assign mag     = angle[rlvc_pkg::ANG_W-1] ? (~ang_ext + 17'd1) : ang_ext;

	assign accel_prod = mag * cfg.angular_accel;
	assign ang_prod   = mag * cfg.inv_horizon;
	assign lin_prod   = distance * cfg.inv_horizon;

	// magnitude is truncated, so the scaled angle rounds toward zero
	assign ang_scaled = ang_prod[31:rlvc_pkg::FRAC_W];
	assign lin_scaled = lin_prod[29:rlvc_pkg::FRAC_W];

	assign ang_cap = (ang_scaled > {5'd0, cfg.max_angular}) ? cfg.max_angular
		: ang_scaled[rlvc_pkg::CFG_W-1:0];

	always_comb begin
		prep.mode    = mode;
		prep.neg     = angle[rlvc_pkg::ANG_W-1];
		prep.in_band = mag <= {2'd0, cfg.heading_band};
		prep.slow    = accel_prod <= {5'd0, cfg.max_angular, 12'd0};
		prep.lin_tgt = (lin_scaled > {3'd0, cfg.max_linear}) ? cfg.max_linear
			: lin_scaled[rlvc_pkg::CFG_W-1:0];
		prep.ang_tgt = angle[rlvc_pkg::ANG_W-1] ? (16'd0 - {1'b0, ang_cap}) : {1'b0, ang_cap};
	end

endmodule

>>> hw/rtl/rlvc_update.sv
// ----------------------------------------------------------------------------
// rlvc_update
// State dependent part of one tick: rotate mode ramping and drive mode
// acceleration and sign-change limits, then saturation.
// ----------------------------------------------------------------------------
module rlvc_update (
	input  rlvc_pkg::prep_t                   prep,
	input  rlvc_pkg::cfg_t                    cfg,
	input  logic [rlvc_pkg::CFG_W-1:0]        last_lin,
	input  logic signed [rlvc_pkg::ANG_W-1:0] last_ang,
	output logic [rlvc_pkg::CFG_W-1:0]        next_lin,
	output logic signed [rlvc_pkg::ANG_W-1:0] next_ang,
	output logic [rlvc_pkg::CFG_W-1:0]        res_lin,
	output logic                              res_turning
);

	localparam int W = rlvc_pkg::WIDE_W;
	localparam logic signed [W-1:0] ZERO_W = '0;

	logic signed [W-1:0] old_a, step_a, min_a, max_a;
	logic signed [W-1:0] old_l, step_l, max_l, tgt_l, up_l, dn_l, lin_w, drv_lin;
	logic signed [W-1:0] acc_t, rot_a;
	logic signed [W-1:0] at, a1, diff, a2, drv_ang;
	logic                chg;
	logic                lin_ge;
	logic [rlvc_pkg::CFG_W-1:0] lin_dec;

	always_comb begin
		old_a  = $signed({{3{last_ang[rlvc_pkg::ANG_W-1]}}, last_ang});
		step_a = $signed({4'd0, cfg.angular_step});
		min_a  = $signed({4'd0, cfg.min_angular});
		max_a  = $signed({4'd0, cfg.max_angular});
		old_l  = $signed({4'd0, last_lin});
		step_l = $signed({4'd0, cfg.linear_step});
		max_l  = $signed({4'd0, cfg.max_linear});
		tgt_l  = $signed({4'd0, prep.lin_tgt});
		at     = $signed({{3{prep.ang_tgt[rlvc_pkg::ANG_W-1]}}, prep.ang_tgt});

		// rotate mode linear ramp down
		lin_ge  = last_lin >= rlvc_pkg::ROT_LIN_STEP;
		lin_dec = last_lin - rlvc_pkg::ROT_LIN_STEP;

		// rotate mode angular speed
		acc_t = prep.neg ? (old_a - step_a) : (old_a + step_a);
		if (prep.in_band) begin
			rot_a = ZERO_W;
		end else if (prep.slow) begin
			if (prep.neg) begin
				rot_a = (old_a >= -min_a) ? -min_a : (old_a + step_a);
			end else begin
				rot_a = (old_a <= min_a) ? min_a : (old_a - step_a);
			end
		end else if (rlvc_pkg::abs_wide(old_a) < {4'd0, cfg.max_angular}) begin
			if (rlvc_pkg::abs_wide(acc_t) > {4'd0, cfg.max_angular}) begin
				rot_a = prep.neg ? -max_a : max_a;
			end else begin
				rot_a = acc_t;
			end
		end else begin
			rot_a = old_a;
		end

		// drive mode linear limit
		up_l  = old_l + step_l;
		dn_l  = old_l - step_l;
		lin_w = (tgt_l > up_l) ? up_l : ((tgt_l < dn_l) ? dn_l : tgt_l);
		drv_lin = (lin_w > max_l) ? max_l : ((lin_w < ZERO_W) ? ZERO_W : lin_w);

		// drive mode angular acceleration limit
		if (rlvc_pkg::abs_wide(at) > (rlvc_pkg::abs_wide(old_a) + {4'd0, cfg.angular_step})) begin
			a1 = (at < ZERO_W) ? (old_a - step_a) : (old_a + step_a);
		end else begin
			a1 = at;
		end

		// sign change limit, the two cases exclude each other by the sign of old_a
		diff = a1 - old_a;
		chg  = rlvc_pkg::abs_wide(diff) > {4'd0, cfg.angular_step};
		if (a1 < ZERO_W && old_a > ZERO_W && chg) begin
			a2 = old_a - step_a;
		end else if (a1 > ZERO_W && old_a < ZERO_W && chg) begin
			a2 = old_a + step_a;
		end else begin
			a2 = a1;
		end
		drv_ang = (a2 > max_a) ? max_a : ((a2 < -max_a) ? -max_a : a2);

		if (prep.mode) begin
			next_lin    = drv_lin[rlvc_pkg::CFG_W-1:0];
			res_lin     = drv_lin[rlvc_pkg::CFG_W-1:0];
			next_ang    = drv_ang[rlvc_pkg::ANG_W-1:0];
			res_turning = 1'b0;
		end else begin
			next_lin    = lin_ge ? lin_dec : last_lin;
			res_lin     = lin_ge ? lin_dec : '0;
			next_ang    = rot_a[rlvc_pkg::ANG_W-1:0];
			res_turning = !prep.in_band;
		end
	end

endmodule

>>> hw/rtl/rate_limited_velocity_command.sv
// ----------------------------------------------------------------------------
// rate_limited_velocity_command
// Per tick velocity command generator with acceleration, sign-change and
// magnitude limits, in rotate-in-place and drive-to-point modes.
// ----------------------------------------------------------------------------
// One transaction per clock cycle while results are taken. The accepting
// cycle forms the three products of the input with the configuration
// (slow-down test and the two drive targets) into the input register; once the
// result register is free or being taken, the stored linear and angular speed
// are updated and the result register is loaded, from which the result is
// offered. While a result waits to be taken the input register takes one more
// transaction and then holds the input off. Registers must be written only
// while no transaction is in flight; the block itself does not enforce this.
module rate_limited_velocity_command (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rlvc_pkg::IDX_W-1:0]        cfg_index,
	input  logic [rlvc_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic signed [rlvc_pkg::ANG_W-1:0] angle,
	input  logic [rlvc_pkg::CFG_W-1:0]        distance,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rlvc_pkg::CFG_W-1:0]        linear_velocity,
	output logic signed [rlvc_pkg::ANG_W-1:0] angular_velocity,
	output logic                              still_turning
);

	rlvc_pkg::cfg_t  cfg;
	rlvc_pkg::prep_t prep;
	rlvc_pkg::prep_t prep_s1;
	logic            valid_s1;
	logic            valid_s2;
	logic            advance;

	logic [rlvc_pkg::CFG_W-1:0]        last_lin_q;
	logic signed [rlvc_pkg::ANG_W-1:0] last_ang_q;
	logic [rlvc_pkg::CFG_W-1:0]        next_lin;
	logic signed [rlvc_pkg::ANG_W-1:0] next_ang;
	logic [rlvc_pkg::CFG_W-1:0]        res_lin;
	logic                              res_turning;
	logic [rlvc_pkg::CFG_W-1:0]        lin_s2;
	logic signed [rlvc_pkg::ANG_W-1:0] ang_s2;
	logic                              turn_s2;

	rlvc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rlvc_prep u_prep (
		.mode     (mode),
		.angle    (angle),
		.distance (distance),
		.cfg      (cfg),
		.prep     (prep)
	);

	rlvc_update u_update (
		.prep        (prep_s1),
		.cfg         (cfg),
		.last_lin    (last_lin_q),
		.last_ang    (last_ang_q),
		.next_lin    (next_lin),
		.next_ang    (next_ang),
		.res_lin     (res_lin),
		.res_turning (res_turning)
	);

	// stage 1 moves on when the result register is free or being taken
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			last_lin_q <= '0;
			last_ang_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2   <= 1'b1;
				last_lin_q <= next_lin;
				last_ang_q <= next_ang;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prep_s1 <= prep;
		end
		if (advance) begin
			lin_s2  <= res_lin;
			ang_s2  <= next_ang;
			turn_s2 <= res_turning;
		end
	end

	assign out_valid        = valid_s2;
	assign linear_velocity  = lin_s2;
	assign angular_velocity = ang_s2;
	assign still_turning    = turn_s2;

endmodule

>>> tb/sv/tb_rate_limited_velocity_command.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rate_limited_velocity_command
// Self-checking bench for the velocity command generator. A queue-fed
// driver offers ticks in random bursts, a monitor takes results under
// changing stall patterns, and every result is compared with a bit-exact
// predictor that tracks the stored speeds and the register settings.
// ----------------------------------------------------------------------------
module tb_rate_limited_velocity_command;

	localparam logic MODE_ROTATE = 1'b0;
	localparam logic MODE_DRIVE  = 1'b1;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   HOLD_CYCLES = 400;

	typedef logic [rlvc_pkg::CFG_W-1:0] word_t;

	typedef struct packed {
		logic                              mode;
		logic signed [rlvc_pkg::ANG_W-1:0] angle;
		logic [rlvc_pkg::CFG_W-1:0]        distance;
	} tick_t;

	typedef struct packed {
		logic [rlvc_pkg::CFG_W-1:0]        lin;
		logic signed [rlvc_pkg::ANG_W-1:0] ang;
		logic                              turning;
	} vel_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [rlvc_pkg::IDX_W-1:0]        cfg_index = '0;
	logic [rlvc_pkg::CFG_W-1:0]        cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic                              mode = 1'b0;
	logic signed [rlvc_pkg::ANG_W-1:0] angle = '0;
	logic [rlvc_pkg::CFG_W-1:0]        distance = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [rlvc_pkg::CFG_W-1:0]        linear_velocity;
	logic signed [rlvc_pkg::ANG_W-1:0] angular_velocity;
	logic                              still_turning;

	rate_limited_velocity_command u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.angle            (angle),
		.distance         (distance),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.linear_velocity  (linear_velocity),
		.angular_velocity (angular_velocity),
		.still_turning    (still_turning)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers and the stored speeds
	rlvc_pkg::cfg_t                    cfg_shadow;
	logic [rlvc_pkg::CFG_W-1:0]        speed_lin = '0;
	logic signed [rlvc_pkg::ANG_W-1:0] speed_ang = '0;

	tick_t tick_pending [$];
	vel_t  vel_expected [$];
	int    ticks_issued = 0;
	int    ticks_taken = 0;
	int    mismatches = 0;
	int    cycle_n = 0;
	int    hold_left = 0;
	int    next_hold_at = 300;

	function automatic longint abs_l(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// magnitude truncated, so the product rounds toward zero
	function automatic longint times_inv_horizon(input longint v, input longint k);
		longint p;
		p = (abs_l(v) * k) >>> rlvc_pkg::FRAC_W;
		return (v < 0) ? -p : p;
	endfunction

	function automatic vel_t next_command(input logic m,
		input logic signed [rlvc_pkg::ANG_W-1:0] a_in, input logic [rlvc_pkg::CFG_W-1:0] d_in);
		longint a, mag, lin, ang, old_lin, old_ang;
		longint band, accel, astep, lstep, amax, amin, lmax, invh;
		vel_t v;
		band    = longint'(cfg_shadow.heading_band);
		accel   = longint'(cfg_shadow.angular_accel);
		astep   = longint'(cfg_shadow.angular_step);
		lstep   = longint'(cfg_shadow.linear_step);
		amax    = longint'(cfg_shadow.max_angular);
		amin    = longint'(cfg_shadow.min_angular);
		lmax    = longint'(cfg_shadow.max_linear);
		invh    = longint'(cfg_shadow.inv_horizon);
		a       = longint'(a_in);
		mag     = abs_l(a);
		old_lin = longint'(speed_lin);
		old_ang = longint'(speed_ang);
		v.turning = 1'b0;
		if (m == MODE_ROTATE) begin
			// below one ramp step the stored speed is kept but zero is commanded
			v.lin = '0;
			if (speed_lin >= rlvc_pkg::ROT_LIN_STEP) begin
				speed_lin = speed_lin - rlvc_pkg::ROT_LIN_STEP;
				v.lin = speed_lin;
			end
			ang = old_ang;
			if (mag <= band) begin
				ang = 0;
			end else begin
				v.turning = 1'b1;
				if (mag * accel <= (amax << rlvc_pkg::FRAC_W)) begin
					if (a < 0) begin
						if (ang >= -amin) ang = -amin;
						else ang = ang + astep;
					end else begin
						if (ang <= amin) ang = amin;
						else ang = ang - astep;
					end
				end else if (abs_l(ang) < amax) begin
					if (a < 0) begin
						ang = ang - astep;
						if (abs_l(ang) > amax) ang = -amax;
					end else begin
						ang = ang + astep;
						if (abs_l(ang) > amax) ang = amax;
					end
				end
			end
			speed_ang = ang[rlvc_pkg::ANG_W-1:0];
			v.ang = speed_ang;
		end else begin
			lin = times_inv_horizon(longint'(d_in), invh);
			ang = times_inv_horizon(a, invh);
			if (lin > lmax) lin = lmax;
			if (abs_l(ang) > amax) ang = (ang < 0) ? -amax : amax;
			if (lin > old_lin + lstep) lin = old_lin + lstep;
			else if (lin < old_lin - lstep) lin = old_lin - lstep;
			if (abs_l(ang) > abs_l(old_ang) + astep)
				ang = (ang < 0) ? old_ang - astep : old_ang + astep;
			// sign change limited to one step
			if (ang < 0 && old_ang > 0 && abs_l(ang - old_ang) > astep) ang = old_ang - astep;
			if (ang > 0 && old_ang < 0 && abs_l(ang - old_ang) > astep) ang = old_ang + astep;
			if (ang > amax) ang = amax;
			if (ang < -amax) ang = -amax;
			if (lin > lmax) lin = lmax;
			if (lin < 0) lin = 0;
			speed_lin = lin[rlvc_pkg::CFG_W-1:0];
			speed_ang = ang[rlvc_pkg::ANG_W-1:0];
			v.lin = speed_lin;
			v.ang = speed_ang;
		end
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40) $display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic push_tick(input logic m, input logic signed [rlvc_pkg::ANG_W-1:0] a,
		input logic [rlvc_pkg::CFG_W-1:0] d);
		tick_t t;
		t.mode = m;
		t.angle = a;
		t.distance = d;
		tick_pending.insert(tick_pending.size(), t);
		ticks_issued++;
	endtask

	task automatic write_reg(input logic [rlvc_pkg::IDX_W-1:0] idx,
		input logic [rlvc_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			rlvc_pkg::REG_HEADING_BAND:      cfg_shadow.heading_band = val;
			rlvc_pkg::REG_ANGULAR_ACCEL:     cfg_shadow.angular_accel = val;
			rlvc_pkg::REG_ANGULAR_STEP:      cfg_shadow.angular_step = val;
			rlvc_pkg::REG_LINEAR_STEP:       cfg_shadow.linear_step = val;
			rlvc_pkg::REG_MAX_ANGULAR:       cfg_shadow.max_angular = val;
			rlvc_pkg::REG_MIN_ANGULAR:       cfg_shadow.min_angular = val;
			rlvc_pkg::REG_MAX_LINEAR:        cfg_shadow.max_linear = val;
			default:                         cfg_shadow.inv_horizon = val;
		endcase
	endtask

	// all transactions answered and their results taken
	task automatic wait_drained();
		while (ticks_taken != ticks_issued || vel_expected.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_setting(input int k);
		logic [rlvc_pkg::IDX_W-1:0] idx_list [8];
		logic [rlvc_pkg::CFG_W-1:0] rst_list [8];
		logic [rlvc_pkg::CFG_W-1:0] v;
		idx_list = '{rlvc_pkg::REG_HEADING_BAND, rlvc_pkg::REG_ANGULAR_ACCEL,
			rlvc_pkg::REG_ANGULAR_STEP, rlvc_pkg::REG_LINEAR_STEP, rlvc_pkg::REG_MAX_ANGULAR,
			rlvc_pkg::REG_MIN_ANGULAR, rlvc_pkg::REG_MAX_LINEAR, rlvc_pkg::REG_INV_HORIZON};
		rst_list = '{rlvc_pkg::RST_HEADING_BAND, rlvc_pkg::RST_ANGULAR_ACCEL,
			rlvc_pkg::RST_ANGULAR_STEP, rlvc_pkg::RST_LINEAR_STEP, rlvc_pkg::RST_MAX_ANGULAR,
			rlvc_pkg::RST_MIN_ANGULAR, rlvc_pkg::RST_MAX_LINEAR, rlvc_pkg::RST_INV_HORIZON};
		for (int i = 0; i < 8; i++) begin
			case (k)
				0: v = rst_list[i];
				1: v = '0;
				2: v = '1;
				3: v = word_t'($urandom_range(0, 32767));
				default: begin
					case ($urandom_range(0, 5))
						0: v = '0;
						1: v = '1;
						2: v = word_t'($urandom_range(0, 32767));
						default: begin
							if (idx_list[i] == rlvc_pkg::REG_ANGULAR_STEP
								|| idx_list[i] == rlvc_pkg::REG_LINEAR_STEP)
								v = word_t'($urandom_range(1, 1200));
							else
								v = word_t'($urandom_range(0, 8192));
						end
					endcase
				end
			endcase
			write_reg(idx_list[i], v);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// runs of one mode with random content, a few stray ticks of the other mode
	task automatic add_random(input int n);
		int left, run;
		logic m, mt;
		longint a, b, band, amax, accel;
		logic [rlvc_pkg::CFG_W-1:0] d;
		left = n;
		while (left > 0) begin
			m = 1'($urandom_range(0, 1));
			run = $urandom_range(1, 16);
			while (run > 0 && left > 0) begin
				band  = longint'(cfg_shadow.heading_band);
				amax  = longint'(cfg_shadow.max_angular);
				accel = longint'(cfg_shadow.angular_accel);
				mt = ($urandom_range(0, 9) == 0) ? ~m : m;
				case ($urandom_range(0, 9))
					0, 1, 2, 3: a = $urandom_range(0, 65535);
					4, 5, 6:    a = $urandom_range(0, 1500);
					7, 8:       a = band + $urandom_range(0, 2) - 1;
					default: begin
						// around the slow-down threshold, or a full-scale angle
						b = 32767;
						if (accel != 0 && ((amax << rlvc_pkg::FRAC_W) / accel) < 32767)
							b = ((amax << rlvc_pkg::FRAC_W) / accel) + $urandom_range(0, 1);
						a = ($urandom_range(0, 2) == 0) ? -32768 : b;
					end
				endcase
				if ($urandom_range(0, 1) == 1) a = -a;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: d = word_t'($urandom_range(0, 32767));
					5, 6, 7, 8:    d = word_t'($urandom_range(0, 3000));
					default:       d = ($urandom_range(0, 1) == 1) ? '1 : '0;
				endcase
				push_tick(mt, a[rlvc_pkg::ANG_W-1:0], d);
				run--;
				left--;
			end
		end
	endtask

	// driver
	int    burst_left = 0;
	int    gap_left = 0;
	tick_t next_tick;
	logic  offer;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				vel_expected.insert(vel_expected.size(), next_command(mode, angle, distance));
				ticks_taken++;
			end
			if (!in_valid || in_ready) begin
				offer = 1'b0;
				// keep offering while the receiver is held off
				if (gap_left != 0 && hold_left == 0) begin
					gap_left--;
				end else if (tick_pending.size() != 0) begin
					next_tick = tick_pending.pop_front();
					mode <= next_tick.mode;
					angle <= next_tick.angle;
					distance <= next_tick.distance;
					offer = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				in_valid <= offer;
			end
		end
	end

	// long receiver hold-off so the block fills and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			next_hold_at <= 300;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (ticks_taken >= next_hold_at) begin
			hold_left <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + 500;
		end
	end

	// monitor
	int   stall_left = 0;
	int   stall_kind = 0;
	int   stall_cnt = 0;
	logic take;
	vel_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			stall_kind = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (vel_expected.size() == 0) begin
					report_mismatch($sformatf("result with none expected lin=%0d ang=%0d turn=%0b",
						linear_velocity, angular_velocity, still_turning));
				end else begin
					want = vel_expected.pop_front();
					if (linear_velocity !== want.lin)
						report_mismatch($sformatf("linear_velocity %0d, expected %0d",
							linear_velocity, want.lin));
					if (angular_velocity !== want.ang)
						report_mismatch($sformatf("angular_velocity %0d, expected %0d",
							angular_velocity, want.ang));
					if (still_turning !== want.turning)
						report_mismatch($sformatf("still_turning %0b, expected %0b",
							still_turning, want.turning));
				end
			end
			if (stall_left == 0) begin
				stall_kind = $urandom_range(0, 3);
				stall_left = $urandom_range(40, 160);
			end else begin
				stall_left--;
			end
			stall_cnt++;
			case (stall_kind)
				0:       take = 1'b1;
				1:       take = 1'($urandom_range(0, 1));
				2:       take = (stall_cnt % 4 == 0);
				default: take = ($urandom_range(0, 6) != 0);
			endcase
			out_ready <= take && (hold_left == 0);
		end
	end

	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n == CYCLE_LIMIT) begin
			$display("FAIL rate_limited_velocity_command");
			$finish;
		end
	end

	initial begin
		cfg_shadow.heading_band      = rlvc_pkg::RST_HEADING_BAND;
		cfg_shadow.angular_accel     = rlvc_pkg::RST_ANGULAR_ACCEL;
		cfg_shadow.angular_step      = rlvc_pkg::RST_ANGULAR_STEP;
		cfg_shadow.linear_step       = rlvc_pkg::RST_LINEAR_STEP;
		cfg_shadow.max_angular       = rlvc_pkg::RST_MAX_ANGULAR;
		cfg_shadow.min_angular       = rlvc_pkg::RST_MIN_ANGULAR;
		cfg_shadow.max_linear        = rlvc_pkg::RST_MAX_LINEAR;
		cfg_shadow.inv_horizon       = rlvc_pkg::RST_INV_HORIZON;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed ticks on the reset settings
		push_tick(MODE_ROTATE, 16'sd0, 15'd0);        // aligned, linear below one step
		push_tick(MODE_ROTATE, 16'sd205, 15'd32767);  // band edges
		push_tick(MODE_ROTATE, -16'sd205, 15'd0);
		push_tick(MODE_ROTATE, 16'sd206, 15'd0);      // just outside, slows to min rate
		push_tick(MODE_ROTATE, 16'sd4096, 15'd0);     // slow-down test at exact equality
		push_tick(MODE_ROTATE, 16'sd32767, 15'd0);    // speeds up
		push_tick(MODE_ROTATE, 16'sd4096, 15'd0);     // slows by one step
		push_tick(MODE_ROTATE, 16'sd4097, 15'd0);
		for (int i = 0; i < 7; i++) push_tick(MODE_ROTATE, 16'sd32767, 15'd100);
		push_tick(MODE_ROTATE, -16'sd32768, 15'd0);   // at the cap, speed kept
		push_tick(MODE_ROTATE, -16'sd206, 15'd0);
		push_tick(MODE_DRIVE, 16'sd32767, 15'd32767); // both targets saturate
		push_tick(MODE_DRIVE, 16'sd1, 15'd600);       // linear target within one step
		push_tick(MODE_DRIVE, -16'sd32768, 15'd0);
		push_tick(MODE_ROTATE, -16'sd32768, 15'd0);
		push_tick(MODE_DRIVE, 16'sd32767, 15'd32767);
		push_tick(MODE_DRIVE, 16'sd32767, 15'd32767);
		push_tick(MODE_ROTATE, 16'sd0, 15'd0);        // linear ramps down
		push_tick(MODE_DRIVE, -16'sd1, 15'd32767);
		wait_drained();

		for (int k = 0; k < 9; k++) begin
			apply_setting(k);
			add_random(128);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && vel_expected.size() == 0) begin
			$display("PASS rate_limited_velocity_command");
		end else begin
			$display("FAIL rate_limited_velocity_command");
		end
		$finish;
	end

endmodule
